// File: rtl/assert_macros.svh
// Assertion helpers shared by the RTL; every check is clocked on clk and
// switched off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define AFS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define AFS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/afs_pkg.sv
package afs_pkg;

  localparam int unsigned THUMB_WIDTH    = 148;
  localparam int unsigned THUMB_HEIGHT   = 84;
  localparam int unsigned MAX_SOURCE_DIM = 8192;

  localparam int unsigned DIM_W   = 14;  // configured dimension
  localparam int unsigned XW      = 8;   // thumb_x
  localparam int unsigned YW      = 7;   // thumb_y
  localparam int unsigned SRC_W   = 13;
  localparam int unsigned IDX_W   = 26;
  localparam int unsigned NUM_W   = 8;   // ratio numerator (thumb size)
  localparam int unsigned QW      = 14;  // quotient bits, one per cell
  localparam int unsigned PW      = 22;  // per-item dividend
  localparam int unsigned DIVW    = 21;  // fitted-size dividend
  localparam int unsigned CNT_W   = 5;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = CFG_IDX_W'(1);

  typedef struct packed {
    logic [XW-1:0] thumb_x;
    logic [YW-1:0] thumb_y;
  } in_word_t;

  typedef struct packed {
    logic             in_image;
    logic [SRC_W-1:0] src_x;
    logic [SRC_W-1:0] src_y;
    logic [IDX_W-1:0] src_index;
  } out_word_t;

  typedef enum logic [1:0] {
    G_IDLE,
    G_CMP,
    G_DIV,
    G_FIN
  } geom_state_t;

  typedef struct packed {
    logic             busy;
    logic             blank;
    logic [NUM_W-1:0] num;
    logic [DIM_W-1:0] den;
    logic [XW-1:0]    ox;
    logic [YW-1:0]    oy;
    logic [XW-1:0]    dw;
    logic [YW-1:0]    dh;
    logic [DIM_W-1:0] sw;
    logic [DIM_W-1:0] sh;
  } geom_t;

  typedef struct packed {
    logic          in_image;
    logic [PW-1:0] px;
    logic [PW-1:0] py;
    logic [QW-1:0] qx;
    logic [QW-1:0] qy;
  } cell_word_t;

endpackage

// File: rtl/aspect_fit_thumbnail_address_gen.sv
// Aspect-fit thumbnail address generator.
// Input channel: in_valid/in_stall carrying in_data (thumb_x, thumb_y). A word
// is taken on a clock edge with in_valid high and in_stall low.
// Output channel: out_valid/out_stall carrying out_data (in_image, src_x,
// src_y, src_index); the sink holds out_stall high to keep a word waiting.
// Config channel: cfg_valid/cfg_ready with cfg_index (0 width, 1 height) and
// cfg_data. Every write starts a recalculation of the fitted window (one
// compare, 21 divide steps, one finish); cfg_ready and the input are held
// off meanwhile, for only the compare when a dimension is zero.
// Throughput is one word per cycle unless a recalculation or out_stall holds
// the pipe. A word passes one front stage (window test, offset, multiply), a
// chain of 14 divide cells, one quotient bit each, and the linear-index stage.
// Every stage has its own valid and takes a new word whenever the stage below
// is empty or moving, so bubbles close up and a waiting result does not stop
// accepting until the pipe is full; out_stall then backs up to in_stall.
// Reset empties the pipe, clears both dimensions to zero (all letterbox) and
// leaves the block ready for configuration.
`include "assert_macros.svh"

module aspect_fit_thumbnail_address_gen
  import afs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_word_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_word_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data
);

  geom_t        geom;
  logic         f_v_r;
  cell_word_t   f_w_r, f_w_nxt;
  logic         f_ready;
  logic         c_valid [QW+1];
  cell_word_t   c_word  [QW+1];
  logic         c_ready [QW+1];
  logic         in_win;
  logic [XW:0]  x_end;
  logic [YW:0]  y_end;
  logic [XW-1:0] dx;
  logic [YW-1:0] dy;
  logic         tail_ready;
  logic         out_v_r;
  out_word_t    out_w_r, out_w_nxt;
  logic [QW-1:0] lim_x, lim_y;
  logic [SRC_W-1:0] sx, sy;

  afs_geom u_geom (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .geom      (geom)
  );

  // front stage: window test and scaled offset
  assign x_end  = {1'b0, geom.ox} + {1'b0, geom.dw};
  assign y_end  = {1'b0, geom.oy} + {1'b0, geom.dh};
  assign in_win = !geom.blank &&
                  in_data.thumb_x >= geom.ox && {1'b0, in_data.thumb_x} < x_end &&
                  in_data.thumb_y >= geom.oy && {1'b0, in_data.thumb_y} < y_end;
  assign dx     = in_data.thumb_x - geom.ox;
  assign dy     = in_data.thumb_y - geom.oy;

  always_comb begin
    f_w_nxt          = '0;
    f_w_nxt.in_image = in_win;
    if (in_win) begin
      f_w_nxt.px = PW'(dx) * PW'(geom.den);
      f_w_nxt.py = PW'(dy) * PW'(geom.den);
    end
  end

  assign f_ready  = !f_v_r || c_ready[0];
  assign in_stall = geom.busy || !f_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else if (f_ready) begin
      f_v_r <= in_valid && !geom.busy;
    end
  end

  always_ff @(posedge clk) begin
    if (f_ready && in_valid && !geom.busy) f_w_r <= f_w_nxt;
  end

  assign c_valid[0] = f_v_r;
  assign c_word[0]  = f_w_r;

  for (genvar k = 0; k < QW; k++) begin : g_cell
    afs_div_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .num        (geom.num),
      .up_valid   (c_valid[k]),
      .up_word    (c_word[k]),
      .up_ready   (c_ready[k]),
      .down_valid (c_valid[k+1]),
      .down_word  (c_word[k+1]),
      .down_ready (c_ready[k+1])
    );
  end

  // tail: clamp to the last column and row, form the linear index
  assign tail_ready  = !out_v_r || !out_stall;
  assign c_ready[QW] = tail_ready;
  assign lim_x       = geom.sw - QW'(1);
  assign lim_y       = geom.sh - QW'(1);
  assign sx = (c_word[QW].qx > lim_x) ? lim_x[SRC_W-1:0] : c_word[QW].qx[SRC_W-1:0];
  assign sy = (c_word[QW].qy > lim_y) ? lim_y[SRC_W-1:0] : c_word[QW].qy[SRC_W-1:0];

  always_comb begin
    out_w_nxt = '0;
    if (c_word[QW].in_image) begin
      out_w_nxt.in_image  = 1'b1;
      out_w_nxt.src_x     = sx;
      out_w_nxt.src_y     = sy;
      out_w_nxt.src_index = IDX_W'(sy) * IDX_W'(geom.sw) + IDX_W'(sx);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (tail_ready) begin
      out_v_r <= c_valid[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (tail_ready && c_valid[QW]) out_w_r <= out_w_nxt;
  end

  assign out_valid = out_v_r;
  assign out_data  = out_w_r;

  `AFS_ASSERT_IMPL(a_busy_holds_input, geom.busy, in_stall)
  `AFS_ASSERT_IMPL(a_letterbox_zero, out_valid && !out_data.in_image,
                   out_data.src_index == '0 && out_data.src_x == '0 && out_data.src_y == '0)
  `AFS_ASSERT_NEXT(a_full_pipe_stalls, f_v_r && !c_ready[0], f_v_r)

endmodule

// File: rtl/afs_geom.sv
`include "assert_macros.svh"

module afs_geom
  import afs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  output geom_t                geom
);

  geom_state_t      state_r, state_nxt;
  logic [DIM_W-1:0] sw_r, sh_r, wr_val;
  logic             blank_r, sel_h_r;
  logic [NUM_W-1:0] num_r;
  logic [DIM_W-1:0] den_r;
  logic [DIM_W-1:0] rem_r;
  logic [DIVW-1:0]  quo_r;
  logic [CNT_W-1:0] cnt_r;
  logic [XW-1:0]    dw_r, ox_r;
  logic [YW-1:0]    dh_r, oy_r;
  logic             busy;
  logic             wr;
  logic             sel_h;
  logic [DIM_W:0]   rem_sh;
  logic             ge;
  logic [XW-1:0]    dw_fit;
  logic [YW-1:0]    dh_fit;

  assign wr     = cfg_valid && cfg_ready;
  assign wr_val = (cfg_data > DIM_W'(MAX_SOURCE_DIM)) ? DIM_W'(MAX_SOURCE_DIM) : cfg_data;
  assign sel_h  = (23'(THUMB_HEIGHT) * 23'(sw_r)) < (23'(THUMB_WIDTH) * 23'(sh_r));
  assign rem_sh = {rem_r, quo_r[DIVW-1]};
  assign ge     = rem_sh >= {1'b0, den_r};

  // clamp the divided dimension to 1..thumb size
  always_comb begin
    dw_fit = XW'(THUMB_WIDTH);
    dh_fit = YW'(THUMB_HEIGHT);
    if (sel_h_r) begin
      if (quo_r == '0) dw_fit = XW'(1);
      else if (quo_r < DIVW'(THUMB_WIDTH)) dw_fit = quo_r[XW-1:0];
    end else begin
      if (quo_r == '0) dh_fit = YW'(1);
      else if (quo_r < DIVW'(THUMB_HEIGHT)) dh_fit = quo_r[YW-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      G_IDLE: if (wr) state_nxt = G_CMP;
      G_CMP:  if (sw_r == '0 || sh_r == '0) state_nxt = G_IDLE;
              else state_nxt = G_DIV;
      G_DIV:  if (cnt_r == CNT_W'(DIVW-1)) state_nxt = G_FIN;
      G_FIN:  state_nxt = G_IDLE;
      default: state_nxt = G_IDLE;
    endcase
  end

  always_comb begin
    case (state_r)
      G_IDLE:  busy = 1'b0;
      default: busy = 1'b1;
    endcase
  end

  assign cfg_ready = !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= G_IDLE;
      sw_r    <= '0;
      sh_r    <= '0;
      blank_r <= 1'b1;
    end else begin
      state_r <= state_nxt;
      if (wr && cfg_index == REG_SOURCE_WIDTH) sw_r <= wr_val;
      if (wr && cfg_index == REG_SOURCE_HEIGHT) sh_r <= wr_val;
      if (state_r == G_CMP) blank_r <= (sw_r == '0 || sh_r == '0);
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      G_CMP: begin
        sel_h_r <= sel_h;
        cnt_r   <= '0;
        rem_r   <= '0;
        if (sel_h) begin
          num_r <= NUM_W'(THUMB_HEIGHT);
          den_r <= sh_r;
          quo_r <= DIVW'(sw_r) * DIVW'(THUMB_HEIGHT);
        end else begin
          num_r <= NUM_W'(THUMB_WIDTH);
          den_r <= sw_r;
          quo_r <= DIVW'(sh_r) * DIVW'(THUMB_WIDTH);
        end
      end
      G_DIV: begin
        // one quotient bit per cycle, dividend shifted out of quo_r
        rem_r <= ge ? DIM_W'(rem_sh - {1'b0, den_r}) : rem_sh[DIM_W-1:0];
        quo_r <= {quo_r[DIVW-2:0], ge};
        cnt_r <= cnt_r + CNT_W'(1);
      end
      G_FIN: begin
        dw_r <= dw_fit;
        dh_r <= dh_fit;
        ox_r <= (XW'(THUMB_WIDTH) - dw_fit) >> 1;
        oy_r <= (YW'(THUMB_HEIGHT) - dh_fit) >> 1;
      end
      default: ;
    endcase
  end

  assign geom.busy  = busy;
  assign geom.blank = blank_r;
  assign geom.num   = num_r;
  assign geom.den   = den_r;
  assign geom.ox    = ox_r;
  assign geom.oy    = oy_r;
  assign geom.dw    = dw_r;
  assign geom.dh    = dh_r;
  assign geom.sw    = sw_r;
  assign geom.sh    = sh_r;

  `AFS_ASSERT_NEXT(a_write_starts_recalc, cfg_valid && cfg_ready, !cfg_ready)
  `AFS_ASSERT_IMPL(a_div_count_bound, state_r == G_DIV, cnt_r < CNT_W'(DIVW))

endmodule

// File: rtl/afs_div_cell.sv
module afs_div_cell
  import afs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [NUM_W-1:0] num,
  input  logic             up_valid,
  input  cell_word_t       up_word,
  output logic             up_ready,
  output logic             down_valid,
  output cell_word_t       down_word,
  input  logic             down_ready
);

  logic          v_r;
  cell_word_t    w_r, w_nxt;
  logic [PW-1:0] dsr;
  logic          gx, gy;
  logic [PW-1:0] rx, ry;

  // divisor aligned to the top quotient bit; the dividend walks left instead
  assign dsr = PW'(num) << (QW-1);
  assign gx  = up_word.px >= dsr;
  assign gy  = up_word.py >= dsr;
  assign rx  = gx ? up_word.px - dsr : up_word.px;
  assign ry  = gy ? up_word.py - dsr : up_word.py;

  always_comb begin
    w_nxt          = up_word;
    w_nxt.px       = rx << 1;
    w_nxt.py       = ry << 1;
    w_nxt.qx       = {up_word.qx[QW-2:0], gx};
    w_nxt.qy       = {up_word.qy[QW-2:0], gy};
  end

  assign up_ready   = !v_r || down_ready;
  assign down_valid = v_r;
  assign down_word  = w_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) w_r <= w_nxt;
  end

endmodule

// File: tb/tb_aspect_fit_thumbnail_address_gen.sv
module tb_aspect_fit_thumbnail_address_gen;
  import afs_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_word_t             in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_word_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0]     cfg_data = '0;

  aspect_fit_thumbnail_address_gen u_dut (.*);

  always #5 clk = ~clk;

  // source dimensions as the block should hold them
  int unsigned fit_sw, fit_sh;
  in_word_t    coord_q[$];
  out_word_t   addr_q[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned hold_off = 0;
  int unsigned in_gap = 0, out_gap = 0;
  bit          pressure_on = 1'b0;

  function automatic out_word_t predict_addr(in_word_t w);
    out_word_t r;
    longint unsigned x, y, num, den, dw, dh, ox, oy, sx, sy;
    r = '0;
    x = w.thumb_x;
    y = w.thumb_y;
    if (fit_sw == 0 || fit_sh == 0) return r;
    if (THUMB_HEIGHT * fit_sw < THUMB_WIDTH * fit_sh) begin
      num = THUMB_HEIGHT; den = fit_sh;
    end else begin
      num = THUMB_WIDTH; den = fit_sw;
    end
    dw = (fit_sw * num) / den;
    dh = (fit_sh * num) / den;
    if (dw < 1) dw = 1;
    if (dw > THUMB_WIDTH) dw = THUMB_WIDTH;
    if (dh < 1) dh = 1;
    if (dh > THUMB_HEIGHT) dh = THUMB_HEIGHT;
    ox = (THUMB_WIDTH - dw) / 2;
    oy = (THUMB_HEIGHT - dh) / 2;
    if (x < ox || x >= ox + dw || y < oy || y >= oy + dh) return r;
    sx = ((x - ox) * den) / num;
    if (sx >= fit_sw) sx = fit_sw - 1;
    sy = ((y - oy) * den) / num;
    if (sy >= fit_sh) sy = fit_sh - 1;
    r.in_image  = 1'b1;
    r.src_x     = sx[SRC_W-1:0];
    r.src_y     = sy[SRC_W-1:0];
    r.src_index = IDX_W'(sy * fit_sw + sx);
    return r;
  endfunction

  task automatic write_dim(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
    int unsigned v;
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    v = (val > MAX_SOURCE_DIM) ? MAX_SOURCE_DIM : val;
    if (idx == REG_SOURCE_WIDTH) fit_sw = v;
    else if (idx == REG_SOURCE_HEIGHT) fit_sh = v;
  endtask

  task automatic drain();
    while (coord_q.size() != 0 || addr_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic push_coord(int unsigned x, int unsigned y);
    in_word_t w;
    w.thumb_x = XW'(x);
    w.thumb_y = YW'(y);
    coord_q.push_back(w);
  endtask

  // driver: present the head of the pending queue, random gap between words
  always @(posedge clk) begin
    if (in_valid && !in_stall) begin
      addr_q.push_back(predict_addr(in_data));
      void'(coord_q.pop_front());
      in_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
      if ($urandom_range(0, 1)) in_gap = 0;
    end
    if (in_gap != 0 && !(in_valid && in_stall)) begin
      in_gap--;
      in_valid <= 1'b0;
    end else if (!(in_valid && !in_stall) || coord_q.size() > 1) begin
      if (in_valid && !in_stall) begin
        if (coord_q.size() != 0) begin
          in_valid <= 1'b1;
          in_data  <= coord_q[0];
        end else in_valid <= 1'b0;
      end else if (!in_valid && coord_q.size() != 0 && rst_n) begin
        in_valid <= 1'b1;
        in_data  <= coord_q[0];
      end
    end else in_valid <= 1'b0;
  end

  // long receiver hold-off, counted here while the sender keeps offering words
  always @(posedge clk) begin
    if (pressure_on && hold_off == 0) begin
      hold_off <= 200;
      pressure_on = 1'b0;
    end else if (hold_off != 0) begin
      hold_off <= hold_off - 1;
    end
  end

  // monitor: check each accepted word, random stall per word
  always @(posedge clk) begin
    out_word_t exp_w;
    if (out_valid && !out_stall) begin
      if (addr_q.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %h", $time, out_data);
        errors++;
      end else begin
        exp_w = addr_q.pop_front();
        if (out_data.in_image !== exp_w.in_image)
          $display("%0t: in_image expected %0d actual %0d", $time, exp_w.in_image,
                   out_data.in_image);
        if (out_data.src_x !== exp_w.src_x)
          $display("%0t: src_x expected %0d actual %0d", $time, exp_w.src_x,
                   out_data.src_x);
        if (out_data.src_y !== exp_w.src_y)
          $display("%0t: src_y expected %0d actual %0d", $time, exp_w.src_y,
                   out_data.src_y);
        if (out_data.src_index !== exp_w.src_index)
          $display("%0t: src_index expected %0d actual %0d", $time, exp_w.src_index,
                   out_data.src_index);
        if (out_data !== exp_w) errors++;
      end
      out_gap = $urandom_range(0, 1) ? 0 : $urandom_range(0, 15);
    end
    if (hold_off != 0) begin
      out_stall <= 1'b1;
    end else if (out_gap != 0) begin
      out_gap--;
      out_stall <= 1'b1;
    end else out_stall <= 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 400000) begin
      $display("tb_aspect_fit_thumbnail_address_gen failed");
      $finish;
    end
  end

  initial begin
    int unsigned dims[12][2];
    fit_sw = 0;
    fit_sh = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    // registers at reset: everything letterbox
    push_coord(0, 0);
    push_coord(74, 42);
    drain();
    dims = '{'{8192, 8192}, '{1, 1}, '{148, 84}, '{1920, 1080}, '{16383, 1},
             '{1, 8192}, '{0, 100}, '{640, 480}, '{8192, 3}, '{13, 8191},
             '{1279, 721}, '{296, 168}};
    foreach (dims[i]) begin
      write_dim(REG_SOURCE_WIDTH, DIM_W'(dims[i][0]));
      write_dim(REG_SOURCE_HEIGHT, DIM_W'(dims[i][1]));
      // drop a write with an unused index
      write_dim(CFG_IDX_W'(2 + (i % 2)), DIM_W'($urandom));
      if (i == 0) begin
        push_coord(0, 0);
        push_coord(147, 83);
        push_coord(255, 127);
        push_coord(148, 0);
        push_coord(0, 84);
        push_coord(170, 85);
      end
      if (i == 3) pressure_on = 1'b1;
      repeat (60) begin
        if ($urandom_range(0, 9) == 0) push_coord($urandom_range(0, 255),
                                                   $urandom_range(0, 127));
        else push_coord($urandom_range(0, THUMB_WIDTH - 1),
                        $urandom_range(0, THUMB_HEIGHT - 1));
      end
      drain();
    end
    if (errors == 0)
      $display("tb_aspect_fit_thumbnail_address_gen passed");
    else
      $display("tb_aspect_fit_thumbnail_address_gen failed");
    $finish;
  end
endmodule

// File: aspect_fit_thumbnail_address_gen.f
+incdir+rtl
rtl/afs_pkg.sv
rtl/afs_geom.sv
rtl/afs_div_cell.sv
rtl/aspect_fit_thumbnail_address_gen.sv
tb/tb_aspect_fit_thumbnail_address_gen.sv
